// ----- hw/rtl/sce_pkg.sv -----
// Package: shared constants, types and helpers for the stereo chorus.
`timescale 1ns / 1ps
package sce_pkg;
	localparam int DelayLenDefault = 4096;
	localparam int SampleW = 24;
	localparam int GainW = 15;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;

	localparam logic [CfgIdxW-1:0] REG_LPF = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RATE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DEPTH = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_BASE = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FB = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_WET = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_REV = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_DLY = 3'd7;

	typedef struct packed {
		logic signed [SampleW-1:0] wet_left;
		logic signed [SampleW-1:0] wet_right;
		logic signed [SampleW-1:0] reverb_send;
		logic signed [SampleW-1:0] delay_send;
	} result_t;

	// saturate a wide signed value to Q1.23
	function automatic logic signed [SampleW-1:0] sat24(input logic signed [47:0] v);
		logic signed [SampleW-1:0] r;
		if (v > 48'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -48'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[SampleW-1:0];
		end
		return r;
	endfunction
endpackage

// ----- hw/rtl/sce_if.sv -----
// Interfaces: sample, result and configuration channels.
`timescale 1ns / 1ps
interface sce_in_if import sce_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SampleW-1:0] sample_in;
	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

interface sce_out_if import sce_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SampleW-1:0] wet_left;
	logic signed [SampleW-1:0] wet_right;
	logic signed [SampleW-1:0] reverb_send;
	logic signed [SampleW-1:0] delay_send;
	modport source(output valid, output wet_left, output wet_right, output reverb_send,
		output delay_send, input ready);
	modport sink(input valid, input wet_left, input wet_right, input reverb_send,
		input delay_send, output ready);
endinterface

interface sce_cfg_if import sce_pkg::*; ();
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDataW-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/sce_mac.sv -----
// Shared multiply unit: one registered signed 25x25 product per cycle.
`timescale 1ns / 1ps
module sce_mac import sce_pkg::*; (
	input logic clk,
	input logic signed [24:0] a,
	input logic signed [24:0] b,
	output logic signed [49:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

// ----- hw/rtl/stereo_chorus_effect.sv -----
// Top level: stereo chorus with shared multiplier and a sequencer.
`timescale 1ns / 1ps
// A sample word's result is put in the output register once the sequencer has worked
// through it, and the next sample is accepted only after that. A sequencer steps a
// single registered 25x25 multiplier through the lowpass, two delay products, four
// interpolation products, two feedback products and four gain products. The one read port
// of each delay line is used for two taps per sample. A finished result waits in an output
// register. The next sample may be taken and worked on meanwhile, and the sequencer holds
// at its last step while the previous result is still unaccepted. After reset a clearing
// pass zeroes both lines, and no sample is accepted meanwhile. Configuration writes are
// always accepted and take effect at once, so write them only while no sample is in flight.
module stereo_chorus_effect import sce_pkg::*; #(
	parameter int DELAY_LEN = DelayLenDefault
) (
	input logic clk,
	input logic arst_n,
	sce_in_if.sink in_ch,
	sce_out_if.source out_ch,
	sce_cfg_if.sink cfg
);
	localparam int AW = $clog2(DELAY_LEN);
	localparam int PW = AW + 8;
	localparam logic [PW:0] MaxD = (PW+1)'(DELAY_LEN) << 8;

	localparam logic [4:0] ST_CLR = 5'd0, ST_IDLE = 5'd1, ST_LPF = 5'd2,
		ST_DL = 5'd3, ST_DR = 5'd4, ST_RD0 = 5'd5, ST_RD1 = 5'd6, ST_IL0 = 5'd7,
		ST_IL1 = 5'd8, ST_IR0 = 5'd9, ST_IR1 = 5'd10, ST_FBL = 5'd11,
		ST_FBR = 5'd12, ST_WL = 5'd13, ST_WR = 5'd14, ST_GM = 5'd15,
		ST_GD = 5'd16, ST_DONE = 5'd17, ST_OUT = 5'd18;

	logic [4:0] st_q;
	logic [AW-1:0] clr_q, wp_q;
	logic [14:0] lpf_q, fb_q, wet_q, rev_q, dly_q;
	logic [23:0] rate_q, phase_q;
	logic [19:0] depth_q, base_q;
	logic signed [23:0] lpm_q, x_q, outl_q, outr_q;
	logic signed [47:0] acc_q;
	logic [PW-1:0] posl_q, posr_q;
	logic signed [23:0] r0_q;
	logic signed [23:0] lrd_q, rrd_q;
	logic [AW-1:0] lra, rra;
	logic signed [23:0] left_mem [DELAY_LEN];
	logic signed [23:0] right_mem [DELAY_LEN];
	logic signed [24:0] ma, mb;
	logic signed [49:0] prod;
	logic signed [47:0] prod48;
	result_t res_q, stg_q;
	logic ovalid_q;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (st_q == ST_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.wet_left = res_q.wet_left;
	assign out_ch.wet_right = res_q.wet_right;
	assign out_ch.reverb_send = res_q.reverb_send;
	assign out_ch.delay_send = res_q.delay_send;

	sce_mac u_mac (.clk(clk), .a(ma), .b(mb), .p_q(prod));
	assign prod48 = prod[47:0];

	// half the triangle: lfo * depth >> 24 equals dev * depth >> 23
	logic [23:0] dev, dev_inv;
	assign dev = (phase_q >= 24'h800000) ? phase_q - 24'h800000 : 24'h800000 - phase_q;
	assign dev_inv = 24'h800000 - dev;
	logic signed [23:0] mono;
	assign mono = 24'((25'(outl_q) + 25'(outr_q)) >>> 1);

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			ST_LPF: begin
				ma = 25'(x_q) - 25'(lpm_q); mb = 25'(lpf_q);
			end
			ST_DL: begin ma = 25'(dev); mb = 25'(depth_q); end
			ST_DR: begin ma = 25'(dev_inv); mb = 25'(depth_q); end
			ST_IL0: begin ma = 25'(lrd_q); mb = 25'(9'd256 - 9'(posl_q[7:0])); end
			ST_IL1: begin ma = 25'(lrd_q); mb = 25'(posl_q[7:0]); end
			ST_IR0: begin ma = 25'(r0_q); mb = 25'(9'd256 - 9'(posr_q[7:0])); end
			ST_IR1: begin ma = 25'(rrd_q); mb = 25'(posr_q[7:0]); end
			ST_FBL: begin ma = 25'(outl_q); mb = 25'(fb_q); end
			ST_FBR: begin ma = 25'(outr_q); mb = 25'(fb_q); end
			ST_WL: begin ma = 25'(outl_q); mb = 25'(wet_q); end
			ST_WR: begin ma = 25'(outr_q); mb = 25'(wet_q); end
			ST_GM: begin ma = 25'(mono); mb = 25'(rev_q); end
			ST_GD: begin ma = 25'(mono); mb = 25'(dly_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// delay to line position, clamped
	function automatic logic [PW-1:0] to_pos(input logic [19:0] b,
			input logic [49:0] p, input logic [AW-1:0] wp);
		logic [34:0] d;
		logic [PW:0] dc;
		logic [PW+1:0] pos;
		d = 35'(b) + 35'(p[49:23]);
		if (d < 35'd256) dc = (PW+1)'(256);
		else if (d > 35'(MaxD)) dc = MaxD;
		else dc = d[PW:0];
		pos = {2'b0, wp, 8'd0} - (PW+2)'(dc);
		if (pos[PW+1]) pos = pos + (PW+2)'(MaxD);
		return pos[PW-1:0];
	endfunction

	// line index plus one, wrapping at the line length
	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(DELAY_LEN - 1)) ? '0 : i + AW'(1);
	endfunction

	// both taps at i0 are read in RD1, the taps at i1 afterwards
	assign lra = (st_q == ST_RD1) ? posl_q[PW-1:8] : next_idx(posl_q[PW-1:8]);
	assign rra = (st_q == ST_RD1) ? posr_q[PW-1:8] : next_idx(posr_q[PW-1:8]);

	// delay line memories: one read and one write port each
	always_ff @(posedge clk) begin
		lrd_q <= left_mem[lra];
		rrd_q <= right_mem[rra];
		if (st_q == ST_CLR) begin
			left_mem[clr_q] <= '0;
			right_mem[clr_q] <= '0;
		end else if (st_q == ST_FBR) begin
			left_mem[wp_q] <= sat24(48'(x_q) + (prod48 >>> 14));
		end else if (st_q == ST_WL) begin
			right_mem[wp_q] <= sat24(48'(x_q) + (prod48 >>> 14));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0; wp_q <= '0; phase_q <= '0; lpm_q <= '0;
			lpf_q <= 15'd16384; rate_q <= '0; depth_q <= '0; base_q <= 20'd256;
			fb_q <= '0; wet_q <= 15'd8192; rev_q <= '0; dly_q <= '0; ovalid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_LPF: lpf_q <= cfg.data[14:0];
					REG_RATE: rate_q <= cfg.data[23:0];
					REG_DEPTH: depth_q <= cfg.data[19:0];
					REG_BASE: base_q <= cfg.data[19:0];
					REG_FB: fb_q <= cfg.data[14:0];
					REG_WET: wet_q <= cfg.data[14:0];
					REG_REV: rev_q <= cfg.data[14:0];
					REG_DLY: dly_q <= cfg.data[14:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DELAY_LEN - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						x_q <= in_ch.sample_in;
						st_q <= ST_LPF;
					end
				end
				ST_LPF: st_q <= ST_DL;
				ST_DL: begin
					if (lpf_q < 15'd16384) begin
						lpm_q <= sat24(48'(lpm_q) + (prod48 >>> 14));
						x_q <= sat24(48'(lpm_q) + (prod48 >>> 14));
					end
					st_q <= ST_DR;
				end
				ST_DR: begin
					posl_q <= to_pos(base_q, prod, wp_q);
					st_q <= ST_RD0;
				end
				ST_RD0: begin
					posr_q <= to_pos(base_q, prod, wp_q);
					st_q <= ST_RD1;
				end
				ST_RD1: begin
					st_q <= ST_IL0;
				end
				ST_IL0: begin
					// right tap 0 was read together with left tap 0
					r0_q <= rrd_q; st_q <= ST_IL1;
				end
				ST_IL1: begin
					acc_q <= prod48; st_q <= ST_IR0;
				end
				default: ;
			endcase
			// remaining steps kept separate for clarity
			case (st_q)
				ST_IR0: begin
					outl_q <= 24'((acc_q + prod48) >>> 8); st_q <= ST_IR1;
				end
				ST_IR1: begin acc_q <= prod48; st_q <= ST_FBL; end
				ST_FBL: begin
					outr_q <= 24'((acc_q + prod48) >>> 8); st_q <= ST_FBR;
				end
				ST_FBR: st_q <= ST_WL;
				ST_WL: st_q <= ST_WR;
				ST_WR: begin stg_q.wet_left <= sat24(prod48 >>> 14); st_q <= ST_GM; end
				ST_GM: begin stg_q.wet_right <= sat24(prod48 >>> 14); st_q <= ST_GD; end
				ST_GD: begin stg_q.reverb_send <= sat24(prod48 >>> 14); st_q <= ST_DONE; end
				ST_DONE: begin
					wp_q <= next_idx(wp_q);
					phase_q <= phase_q + rate_q;
					if (!ovalid_q || out_ch.ready) begin
						res_q.wet_left <= stg_q.wet_left;
						res_q.wet_right <= stg_q.wet_right;
						res_q.reverb_send <= stg_q.reverb_send;
						res_q.delay_send <= sat24(prod48 >>> 14);
						ovalid_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						// hold the word until the previous result is taken
						stg_q.delay_send <= sat24(prod48 >>> 14);
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || out_ch.ready) begin
						res_q <= stg_q;
						ovalid_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- hw/rtl/sce_checker.sv -----
// Checker: port-level properties of the stereo chorus, bound to the top level.
`timescale 1ns / 1ps
module sce_checker import sce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [SampleW-1:0] wet_left
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready [*15]) else $error("ready after accept");
	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid) else $error("result too early");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wet_left))
		else $error("result dropped");
endmodule

bind stereo_chorus_effect sce_checker u_sce_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .wet_left(out_ch.wet_left)
);
